### design/svjsl_pkg.sv
// ----------------------------------------------------------------------------
// svjsl_pkg
// Shared types, constants and helpers for the servo joint slew limiter.
// ----------------------------------------------------------------------------
package svjsl_pkg;

    localparam int JOINTS     = 4;
    localparam int OUT_PULSES = 4;

    localparam int ANGLE_W    = 16;
    localparam int PULSE_W    = 12;
    localparam int STEP_W     = 15;
    localparam int DBAND_W    = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [1:0] FUNC_SET_JOINT = 2'd0;
    localparam logic [1:0] FUNC_TICK      = 2'd1;
    localparam logic [1:0] FUNC_SET_GRIP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 1'd1;

    localparam logic [STEP_W-1:0]  MAX_STEP_RESET = 15'd300;
    localparam logic [DBAND_W-1:0] DEADBAND_RESET = 10'd10;

    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 16'sd18000;
    localparam logic [PULSE_W-1:0]        PULSE_MIN = 12'd500;
    localparam logic [PULSE_W-1:0]        PULSE_MAX = 12'd2500;

    // floor(x/9) == (x * ceil(2^17/9)) >> 17 for x < 32768
    localparam logic [13:0] DIV9_MULT = 14'd14564;

    typedef struct packed {
        logic [1:0]                 func;
        logic [2:0]                 joint;
        logic signed [ANGLE_W-1:0]  angle_cdeg;
        logic                       gripper_closed_in;
    } in_item_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_j0;
        logic [PULSE_W-1:0] pulse_j1;
        logic [PULSE_W-1:0] pulse_j2;
        logic [PULSE_W-1:0] pulse_j3;
        logic               gripper_out;
        logic [3:0]         moved_mask;
    } out_item_t;

    typedef struct packed {
        logic                       set_target;
        logic                       tick;
        logic signed [ANGLE_W-1:0]  angle;
        logic [STEP_W-1:0]          max_step;
        logic [DBAND_W-1:0]         deadband;
    } lane_cmd_t;

    typedef struct packed {
        logic               moved;
        logic [PULSE_W-1:0] pulse;
    } lane_stat_t;

    function automatic logic signed [ANGLE_W-1:0] home_angle(input int idx);
        unique case (idx)
            0:       home_angle = 16'sd9000;
            1:       home_angle = 16'sd1000;
            2:       home_angle = 16'sd1000;
            default: home_angle = 16'sd0;
        endcase
    endfunction

    function automatic logic [PULSE_W-1:0] angle_to_pulse(
        input logic signed [ANGLE_W-1:0] cdeg
    );
        logic [14:0] x;
        logic [28:0] prod;
        if (cdeg < 0) begin
            x = '0;
        end else if (cdeg > ANGLE_MAX) begin
            x = ANGLE_MAX[14:0];
        end else begin
            x = cdeg[14:0];
        end
        prod = 29'(x) * 29'(DIV9_MULT);
        angle_to_pulse = PULSE_MIN + prod[28:17];
    endfunction

endpackage

### design/servo_joint_slew_limiter_unit.sv
// ----------------------------------------------------------------------------
// servo_joint_slew_limiter_unit
// Slew-limited servo joint angles mapped to PWM pulse widths.
// ----------------------------------------------------------------------------
// Input channel s_*: one request per command (set joint target, tick, set
// gripper). Result channel m_*: one result per request with all four pulse
// widths, the gripper level and the mask of joints moved by a tick.
// Config port cfg_*: register 0 max step, register 1 deadband; write when idle.
// Path: a request passes the input register, then the result register that
// drives m_valid; joint state updates as the request moves between the two.
// Throughput: one request per cycle while m_ready is high; the single-pass
// step/clamp/divide-by-9 path between the two registers sets the clock.
// Reset: joints return to home (90, 10, 10, 0 deg), gripper open, config to
// defaults, both registers empty.
// Stall: while m_ready is low the result is held; one more request is taken
// into the input register, then s_ready drops until the result leaves.
// ----------------------------------------------------------------------------
module servo_joint_slew_limiter_unit
    import svjsl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic               in_valid_reg, in_valid_next;
    in_item_t           in_data_reg;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;
    logic               grip_reg, grip_next;
    logic [STEP_W-1:0]  max_step_reg;
    logic [DBAND_W-1:0] deadband_reg;
    logic               advance;

    lane_cmd_t          cmd   [JOINTS];
    lane_stat_t         stat  [JOINTS];
    logic [PULSE_W-1:0] pulse [OUT_PULSES];
    logic [3:0]         mask;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
        grip_next = grip_reg;
        if (advance && in_data_reg.func == FUNC_SET_GRIP) begin
            grip_next = in_data_reg.gripper_closed_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            grip_reg      <= 1'b0;
            max_step_reg  <= MAX_STEP_RESET;
            deadband_reg  <= DEADBAND_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            grip_reg      <= grip_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_MAX_STEP: max_step_reg <= cfg_wdata[STEP_W-1:0];
                    REG_DEADBAND: deadband_reg <= cfg_wdata[DBAND_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    genvar g;
    generate
        for (g = 0; g < JOINTS; g++) begin : g_lane
            always_comb begin
                cmd[g].set_target = advance && (in_data_reg.func == FUNC_SET_JOINT)
                                    && (in_data_reg.joint == 3'(g));
                cmd[g].tick       = advance && (in_data_reg.func == FUNC_TICK);
                cmd[g].angle      = in_data_reg.angle_cdeg;
                cmd[g].max_step   = max_step_reg;
                cmd[g].deadband   = deadband_reg;
            end

            svjsl_joint_lane u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .home_i  (home_angle(g)),
                .cmd     (cmd[g]),
                .stat    (stat[g])
            );
        end

        for (g = 0; g < OUT_PULSES; g++) begin : g_out
            if (g < JOINTS) begin : g_have
                assign pulse[g] = stat[g].pulse;
                assign mask[g]  = stat[g].moved;
            end else begin : g_none
                assign pulse[g] = PULSE_MIN;
                assign mask[g]  = 1'b0;
            end
        end
    endgenerate

    always_comb begin
        out_data_next.pulse_j0    = pulse[0];
        out_data_next.pulse_j1    = pulse[1];
        out_data_next.pulse_j2    = pulse[2];
        out_data_next.pulse_j3    = pulse[3];
        out_data_next.gripper_out = grip_next;
        out_data_next.moved_mask  = mask;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // only ticks may report moved joints
    a_mask_tick_only: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_data_reg.func != FUNC_TICK) |=> out_data_reg.moved_mask == 4'd0)
        else $error("moved_mask set on a non-tick request");

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result register not loaded after advance");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled while result register empty");

    a_pulse_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg.pulse_j0 >= PULSE_MIN)
            && (out_data_reg.pulse_j0 <= PULSE_MAX)
            && (out_data_reg.pulse_j3 >= PULSE_MIN)
            && (out_data_reg.pulse_j3 <= PULSE_MAX))
        else $error("pulse width out of range");

    a_grip_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(grip_reg))
        else $error("gripper changed without a request");

endmodule

### design/svjsl_joint_lane.sv
// ----------------------------------------------------------------------------
// svjsl_joint_lane
// One joint: target/current angle and pulse registers, slew-limited step.
// ----------------------------------------------------------------------------
module svjsl_joint_lane
    import svjsl_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic signed [ANGLE_W-1:0]  home_i,
    input  lane_cmd_t                  cmd,
    output lane_stat_t                 stat
);

    logic signed [ANGLE_W-1:0] target_reg, target_next;
    logic signed [ANGLE_W-1:0] current_reg, current_next;
    logic [PULSE_W-1:0]        pulse_reg, pulse_next;

    logic signed [ANGLE_W:0]   diff;
    logic [ANGLE_W:0]          mag;
    logic signed [ANGLE_W:0]   lim;
    logic signed [ANGLE_W:0]   step;
    logic                      moved;

    always_comb begin
        diff = 17'(target_reg) - 17'(current_reg);
        mag  = diff[ANGLE_W] ? 17'(-diff) : 17'(diff);
        lim  = $signed({2'b00, cmd.max_step});
        if (diff > lim) begin
            step = lim;
        end else if (diff < -lim) begin
            step = -lim;
        end else begin
            step = diff;
        end
        moved = cmd.tick && (mag >= 17'(cmd.deadband)) && (step != '0);

        target_next  = cmd.set_target ? cmd.angle : target_reg;
        // step never overshoots the target, so the sum stays in 16 bits
        current_next = moved ? current_reg + step[ANGLE_W-1:0] : current_reg;
        pulse_next   = moved ? angle_to_pulse(current_next) : pulse_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg  <= home_i;
            current_reg <= home_i;
            pulse_reg   <= angle_to_pulse(home_i);
        end else begin
            target_reg  <= target_next;
            current_reg <= current_next;
            pulse_reg   <= pulse_next;
        end
    end

    assign stat.moved = moved;
    assign stat.pulse = pulse_next;

endmodule

### bench/tb_servo_joint_slew_limiter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_joint_slew_limiter_unit
// Self-checking bench for the servo joint slew limiter. Requests (set target,
// tick, set gripper, unused code) are predicted against a local copy of the
// joint, pulse and gripper state; each result is checked field by field in
// order. Covers directed extremes, result back-pressure, register extremes
// and random traffic under several pacing modes.
// ----------------------------------------------------------------------------
module tb_servo_joint_slew_limiter_unit;
    import svjsl_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         TAIL_CYCLES = 8;
    localparam int         ANGLE_TOP   = 18000;
    localparam int         PULSE_FLOOR = 500;
    localparam logic [1:0] FUNC_NOP    = 2'd3;   // unused code, changes nothing

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // local copy of the joint state
    logic signed [ANGLE_W-1:0] target_cdeg [JOINTS];
    logic signed [ANGLE_W-1:0] actual_cdeg [JOINTS];
    logic [PULSE_W-1:0]        pulse_width [JOINTS];
    logic                      grip_closed;
    logic [STEP_W-1:0]         step_limit;
    logic [DBAND_W-1:0]        dead_band;

    out_item_t pending_results [$];

    int send_idle_pct   = 0;
    int stall_pct       = 0;
    int hold_request    = 0;
    int hold_left       = 0;
    int cycle_count     = 0;
    int requests_sent   = 0;
    int ticks_sent      = 0;
    int joint_moves     = 0;
    int results_checked = 0;
    int reg_settings    = 0;
    int mismatches      = 0;

    servo_joint_slew_limiter_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Verification failed");
        $finish;
    end

    // result side pacing; a hold request forces a long stall
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [PULSE_W-1:0] cdeg_to_pulse(input int cdeg);
        int c;
        c = (cdeg < 0) ? 0 : ((cdeg > ANGLE_TOP) ? ANGLE_TOP : cdeg);
        return PULSE_W'(PULSE_FLOOR + c / 9);
    endfunction

    task automatic reset_joint_state();
        target_cdeg[0] = 16'sd9000;
        target_cdeg[1] = 16'sd1000;
        target_cdeg[2] = 16'sd1000;
        target_cdeg[3] = 16'sd0;
        for (int j = 0; j < JOINTS; j++) begin
            actual_cdeg[j] = target_cdeg[j];
            pulse_width[j] = cdeg_to_pulse(int'(target_cdeg[j]));
        end
        grip_closed = 1'b0;
        step_limit  = 15'd300;
        dead_band   = 10'd10;
    endtask

    function automatic out_item_t predict_servo_result(input in_item_t req);
        out_item_t  res;
        logic [3:0] moved;
        int         lim;
        int         diff;
        int         mag;
        int         stride;
        moved = '0;
        case (req.func)
            FUNC_SET_JOINT: begin
                if (int'(req.joint) < JOINTS)
                    target_cdeg[int'(req.joint)] = req.angle_cdeg;
            end
            FUNC_SET_GRIP: begin
                grip_closed = req.gripper_closed_in;
            end
            FUNC_TICK: begin
                lim = int'(step_limit);
                for (int j = 0; j < JOINTS; j++) begin
                    diff = int'(target_cdeg[j]) - int'(actual_cdeg[j]);
                    mag  = (diff < 0) ? -diff : diff;
                    if (mag >= int'(dead_band)) begin
                        stride = (diff > lim) ? lim : ((diff < -lim) ? -lim : diff);
                        if (stride != 0) begin
                            // stays between old angle and target, so fits 16 bits
                            actual_cdeg[j] = ANGLE_W'(int'(actual_cdeg[j]) + stride);
                            pulse_width[j] = cdeg_to_pulse(int'(actual_cdeg[j]));
                            moved[j]       = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.pulse_j0    = pulse_width[0];
        res.pulse_j1    = pulse_width[1];
        res.pulse_j2    = pulse_width[2];
        res.pulse_j3    = pulse_width[3];
        res.gripper_out = grip_closed;
        res.moved_mask  = moved;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    task automatic check_servo_result(input out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("result without pending request", int'(got.moved_mask), 0);
        end else begin
            want = pending_results.pop_front();
            if (got.pulse_j0 !== want.pulse_j0)
                report_mismatch("pulse_j0", int'(got.pulse_j0), int'(want.pulse_j0));
            if (got.pulse_j1 !== want.pulse_j1)
                report_mismatch("pulse_j1", int'(got.pulse_j1), int'(want.pulse_j1));
            if (got.pulse_j2 !== want.pulse_j2)
                report_mismatch("pulse_j2", int'(got.pulse_j2), int'(want.pulse_j2));
            if (got.pulse_j3 !== want.pulse_j3)
                report_mismatch("pulse_j3", int'(got.pulse_j3), int'(want.pulse_j3));
            if (got.gripper_out !== want.gripper_out)
                report_mismatch("gripper_out", int'(got.gripper_out),
                                int'(want.gripper_out));
            if (got.moved_mask !== want.moved_mask)
                report_mismatch("moved_mask", int'(got.moved_mask), int'(want.moved_mask));
            results_checked++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_servo_result(m_data);
    end

    function automatic in_item_t make_request(input logic [1:0] func, input int joint,
                                              input int angle, input logic grip);
        in_item_t req;
        req.func              = func;
        req.joint             = 3'(joint);
        req.angle_cdeg        = ANGLE_W'(angle);
        req.gripper_closed_in = grip;
        return req;
    endfunction

    function automatic in_item_t random_request();
        int         pick;
        int         angle;
        logic [1:0] func;
        int         joint;
        pick = $urandom_range(99);
        func = (pick < 45) ? FUNC_TICK :
               (pick < 80) ? FUNC_SET_JOINT :
               (pick < 93) ? FUNC_SET_GRIP : FUNC_NOP;
        joint = ($urandom_range(99) < 88) ? $urandom_range(0, 3) : $urandom_range(4, 7);
        pick  = $urandom_range(99);
        if (pick < 55)
            angle = $urandom_range(0, ANGLE_TOP);
        else if (pick < 80)
            // near the present angle, so the error straddles the deadband
            angle = int'(actual_cdeg[joint % JOINTS]) + int'($urandom_range(0, 80)) - 40;
        else if (pick < 90)
            angle = $urandom_range(0, 1) ? int'($urandom_range(0, 1000)) - 1000
                                         : int'($urandom_range(ANGLE_TOP, ANGLE_TOP + 1000));
        else
            angle = $urandom();
        return make_request(func, joint, angle, 1'($urandom_range(0, 1)));
    endfunction

    task automatic send_request(input in_item_t req);
        out_item_t want;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        want = predict_servo_result(req);
        pending_results.push_back(want);
        requests_sent++;
        if (req.func == FUNC_TICK)
            ticks_sent++;
        joint_moves += $countones(want.moved_mask);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_MAX_STEP: step_limit = STEP_W'(value);
            REG_DEADBAND: dead_band  = DBAND_W'(value);
            default: ;
        endcase
    endtask

    task automatic run_random_phase(input int count, input int idle_pct, input int stall,
                                    input int step, input int band);
        drain_results();
        write_register(REG_MAX_STEP, step);
        write_register(REG_DEADBAND, band);
        reg_settings++;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (count) send_request(random_request());
        drain_results();
    endtask

    task automatic test_home_pose();
        send_request(make_request(FUNC_NOP, 7, -32768, 1'b1));
        send_request(make_request(FUNC_SET_GRIP, 0, 0, 1'b1));
        send_request(make_request(FUNC_SET_GRIP, 5, 32767, 1'b0));
        // targets equal angles: nothing moves
        send_request(make_request(FUNC_TICK, 0, 0, 1'b1));
    endtask

    task automatic test_target_extremes();
        send_request(make_request(FUNC_SET_JOINT, 0, ANGLE_TOP, 1'b0));
        send_request(make_request(FUNC_SET_JOINT, 1, -32768, 1'b1));
        send_request(make_request(FUNC_SET_JOINT, 2, 32767, 1'b0));
        send_request(make_request(FUNC_SET_JOINT, 3, 0, 1'b1));
        // out-of-range joint indexes are dropped
        send_request(make_request(FUNC_SET_JOINT, 4, 5000, 1'b0));
        send_request(make_request(FUNC_SET_JOINT, 7, -1, 1'b1));
        send_request(make_request(FUNC_TICK, 3, 0, 1'b0));
        send_request(make_request(FUNC_TICK, 6, 1234, 1'b1));
        // error just below, then at, the deadband
        send_request(make_request(FUNC_SET_JOINT, 3, 9, 1'b0));
        send_request(make_request(FUNC_TICK, 0, 0, 1'b0));
        send_request(make_request(FUNC_SET_JOINT, 3, 10, 1'b0));
        send_request(make_request(FUNC_TICK, 0, 0, 1'b0));
        drain_results();
    endtask

    task automatic test_result_backpressure();
        drain_results();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 120;
        repeat (16) send_request(random_request());
        // sender pauses until every result is back
        drain_results();
        repeat (8) send_request(random_request());
        drain_results();
    endtask

    task automatic test_register_extremes();
        run_random_phase(40, 13, 13, 1, 0);
        run_random_phase(40, 13, 13, 32767, 1023);
        run_random_phase(40, 0, 0, 0, 500);        // zero step: nothing may move
        run_random_phase(40, 13, 13, ANGLE_TOP, 1000);
    endtask

    task automatic test_paced_random_traffic();
        run_random_phase(70, 0, 0, 300, 10);
        run_random_phase(70, 87, 0, $urandom_range(1, 600), $urandom_range(0, 40));
        run_random_phase(70, 0, 87, $urandom_range(1, 3000), $urandom_range(0, 200));
        run_random_phase(70, 13, 13, $urandom_range(1, ANGLE_TOP), $urandom_range(0, 1000));
    endtask

    initial begin
        reset_joint_state();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_home_pose();
        test_target_extremes();
        test_result_backpressure();
        test_register_extremes();
        test_paced_random_traffic();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d requests (%0d ticks, %0d joint moves) over %0d register settings",
                 requests_sent, ticks_sent, joint_moves, reg_settings);
        $display("Checked %0d results under four pacing modes and a long result stall",
                 results_checked);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
